/* hdl/neural_activation_unit_macros.svh */
// Assertion macros for the activation unit.
// Used by the top level only; needs no other file.
`ifndef NEURAL_ACTIVATION_UNIT_MACROS_SVH
`define NEURAL_ACTIVATION_UNIT_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, checked out of reset.
`define NAU_ASSERT_IMP(lbl, clk, rstn, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (a) |-> (c)) \
        else $error("assertion failed");
// Next-cycle implication, checked out of reset.
`define NAU_ASSERT_NXT(lbl, clk, rstn, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (a) |=> (c)) \
        else $error("assertion failed");
`else
`define NAU_ASSERT_IMP(lbl, clk, rstn, a, c)
`define NAU_ASSERT_NXT(lbl, clk, rstn, a, c)
`endif
`endif

/* hdl/nau_pkg.sv */
// Shared types and constants of the activation unit.
// No dependencies; imported by every module.
`timescale 1ns / 1ps
`default_nettype none
package nau_pkg;
    localparam int LANES     = 8;
    localparam int SW        = 32;
    localparam int DIV_BITS  = 18;
    localparam int DIV_BASE  = 4;
    localparam int NSTG      = DIV_BASE + DIV_BITS + 2;
    localparam int LCW       = 4;
    localparam int DATA_W    = ((LANES * SW + LCW + 7) / 8) * 8;

    localparam logic signed [31:0] SIX_Q  = 32'sd393216;
    localparam logic signed [31:0] FIVE_Q = 32'sd327680;
    localparam logic [23:0]        C27_Q  = 24'd1769472;
    localparam logic signed [31:0] HALF_Q = 32'sd32768;
    localparam logic [15:0]        SLOPE_RST = 16'd655;

    typedef enum logic [2:0] {
        MODE_PASS  = 3'd0,
        MODE_RELU  = 3'd1,
        MODE_RELU6 = 3'd2,
        MODE_LEAKY = 3'd3,
        MODE_SIG   = 3'd4
    } nau_mode_t;

    localparam logic [7:0] REG_MODE  = 8'd0;
    localparam logic [7:0] REG_SLOPE = 8'd1;

    // Per-stage load strobes plus the configuration every lane sees.
    typedef struct packed {
        logic [NSTG-1:0] load;
        logic [2:0]      mode;
        logic [15:0]     slope;
    } nau_ctrl_t;
endpackage
`default_nettype wire

/* hdl/neural_activation_unit.sv */
// Top level: configuration registers, lane array and the merged result beat.
// Depends on nau_pkg, nau_flow, nau_lane and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "neural_activation_unit_macros.svh"
// Eight Q15.16 lanes are activated in parallel under the mode register. The block
// takes one beat per cycle unless stalled and passes each result through a pipeline
// deepened by the sigmoid divider, which yields one quotient bit per stage.
// Stalls on the result side fill bubbles in the pipeline before the input stalls.
// Configuration writes are taken at once and belong in idle periods.
module neural_activation_unit import nau_pkg::*; (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [7:0]        cfg_index,
    input  wire logic [15:0]       cfg_data,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    // sample0..sample7 (32 bits each), lanes_valid (4 bits), zero pad
    input  wire logic [DATA_W-1:0] s_tdata,
    input  wire logic              s_tlast,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    // result0..result7 (32 bits each), lanes_out (4 bits), zero pad
    output logic [DATA_W-1:0]      m_tdata,
    output logic                   m_tlast
);
    logic [2:0]  mode_reg;
    logic [15:0] slope_reg;

    // Configuration writes, masked to each register's width.
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_PASS;
            slope_reg <= SLOPE_RST;
        end else if (cfg_valid) begin
            if (cfg_index == REG_MODE)  mode_reg  <= cfg_data[2:0];
            if (cfg_index == REG_SLOPE) slope_reg <= cfg_data;
        end
    end

    nau_ctrl_t       ctrl;
    logic [NSTG-1:0] load;

    nau_flow u_flow (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .out_ready (m_tready),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .load      (load)
    );

    assign ctrl.load  = load;
    assign ctrl.mode  = mode_reg;
    assign ctrl.slope = slope_reg;

    // Lane array.
    logic signed [SW-1:0] y [LANES];
    for (genvar i = 0; i < LANES; i++) begin : g_lane
        nau_lane u_lane (
            .aclk (aclk),
            .ctrl (ctrl),
            .x    ($signed(s_tdata[i*SW +: SW])),
            .y    (y[i])
        );
    end

    // Lane count and last flag ride alongside the lanes.
    logic [LCW-1:0] cnt_reg  [NSTG];
    logic           last_reg [NSTG];
    always_ff @(posedge aclk) begin
        for (int k = 0; k < NSTG; k++) begin
            if (load[k]) begin
                cnt_reg[k]  <= (k == 0) ? s_tdata[LANES*SW +: LCW] : cnt_reg[(k == 0) ? 0 : k - 1];
                last_reg[k] <= (k == 0) ? s_tlast : last_reg[(k == 0) ? 0 : k - 1];
            end
        end
    end

    // Merge the lane results into one output beat.
    always_comb begin
        m_tdata = '0;
        for (int i = 0; i < LANES; i++) begin
            m_tdata[i*SW +: SW] = y[i];
        end
        m_tdata[LANES*SW +: LCW] = cnt_reg[NSTG-1];
    end
    assign m_tlast = last_reg[NSTG-1];

    `NAU_ASSERT_NXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid)
    `NAU_ASSERT_IMP(a_ready_chain, aclk, aresetn, m_tready, s_tready)
    `NAU_ASSERT_IMP(a_stall_cause, aclk, aresetn, !s_tready, m_tvalid && !m_tready)
endmodule
`default_nettype wire

/* hdl/nau_flow.sv */
// Valid/ready chain of the lane pipeline; stages fill bubbles independently.
// Depends on nau_pkg.
`timescale 1ns / 1ps
`default_nettype none
module nau_flow import nau_pkg::*; (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            in_valid,
    input  wire logic            out_ready,
    output logic                 in_ready,
    output logic                 out_valid,
    output logic [NSTG-1:0]      load
);
    logic [NSTG-1:0] v_reg;
    logic [NSTG:0]   rdy;

    // A stage may load when it is empty or its content moves on.
    always_comb begin
        rdy[NSTG] = out_ready;
        for (int k = NSTG - 1; k >= 0; k--) begin
            rdy[k] = !v_reg[k] || rdy[k+1];
        end
    end

    assign load      = rdy[NSTG-1:0];
    assign in_ready  = rdy[0];
    assign out_valid = v_reg[NSTG-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            for (int k = 0; k < NSTG; k++) begin
                if (rdy[k]) begin
                    v_reg[k] <= (k == 0) ? in_valid : v_reg[(k == 0) ? 0 : k - 1];
                end
            end
        end
    end
endmodule
`default_nettype wire

/* hdl/nau_lane.sv */
// One activation lane: simple modes, sigmoid products and a bit-per-stage divider.
// Depends on nau_pkg.
`timescale 1ns / 1ps
`default_nettype none
module nau_lane import nau_pkg::*; (
    input  wire logic                 aclk,
    input  wire nau_ctrl_t            ctrl,
    input  wire logic signed [SW-1:0] x,
    output logic signed [SW-1:0]      y
);
    // Stage 0: input sample and clamped half value.
    logic signed [31:0] x0_reg;
    logic signed [19:0] h0_reg;
    logic signed [31:0] half;
    logic signed [31:0] hcl;
    always_comb begin
        half = x >>> 1;
        if (half > FIVE_Q)       hcl = FIVE_Q;
        else if (half < -FIVE_Q) hcl = -FIVE_Q;
        else                     hcl = half;
    end
    always_ff @(posedge aclk) begin
        if (ctrl.load[0]) begin
            x0_reg <= x;
            h0_reg <= hcl[19:0];
        end
    end

    // Stage 1: h squared, leaky product and the clamp modes.
    logic signed [39:0] hh1_reg;
    logic signed [48:0] lk1_reg;
    logic signed [31:0] x1_reg, s1_reg;
    logic signed [19:0] h1_reg;
    logic signed [31:0] simp;
    always_comb begin
        case (ctrl.mode)
            MODE_RELU:  simp = (x0_reg > 0) ? x0_reg : '0;
            MODE_RELU6: simp = (x0_reg < 0) ? '0 : ((x0_reg > SIX_Q) ? SIX_Q : x0_reg);
            default:    simp = x0_reg;
        endcase
    end
    always_ff @(posedge aclk) begin
        if (ctrl.load[1]) begin
            hh1_reg <= h0_reg * h0_reg;
            lk1_reg <= x0_reg * $signed({1'b0, ctrl.slope});
            x1_reg  <= x0_reg;
            s1_reg  <= simp;
            h1_reg  <= h0_reg;
        end
    end

    // Stage 2: q, numerator factor and denominator; resolve leaky result.
    logic [21:0]        cs2_reg;
    logic [23:0]        d2_reg;
    logic signed [19:0] h2_reg;
    logic signed [31:0] r2_reg;
    logic [20:0]        q1;
    assign q1 = hh1_reg[36:16];
    always_ff @(posedge aclk) begin
        if (ctrl.load[2]) begin
            cs2_reg <= C27_Q[21:0] + {1'b0, q1};
            d2_reg  <= C27_Q + {q1, 3'b000} + {3'b000, q1};
            h2_reg  <= h1_reg;
            if (ctrl.mode == MODE_LEAKY) begin
                r2_reg <= (x1_reg > 0) ? x1_reg : lk1_reg[47:16];
            end else begin
                r2_reg <= s1_reg;
            end
        end
    end

    // Stage 3: numerator product.
    logic signed [42:0] p3_reg;
    logic [23:0]        d3_reg;
    logic signed [31:0] r3_reg;
    always_ff @(posedge aclk) begin
        if (ctrl.load[3]) begin
            p3_reg <= h2_reg * $signed({1'b0, cs2_reg});
            d3_reg <= d2_reg;
            r3_reg <= r2_reg;
        end
    end

    // Divider: entry 0 is the setup stage, each later entry yields one quotient bit.
    logic [23:0]         rem_reg [0:DIV_BITS];
    logic [DIV_BITS-1:0] quo_reg [0:DIV_BITS];
    logic [23:0]         d_reg   [0:DIV_BITS];
    logic [1:0]          lo_reg  [0:DIV_BITS];
    logic                neg_reg [0:DIV_BITS];
    logic signed [31:0]  r_reg   [0:DIV_BITS];

    logic signed [26:0] n3;
    logic [26:0]        nabs;
    assign n3   = p3_reg[42:16];
    assign nabs = n3[26] ? 27'(-n3) : 27'(n3);
    always_ff @(posedge aclk) begin
        if (ctrl.load[DIV_BASE]) begin
            rem_reg[0] <= {1'b0, nabs[24:2]};
            lo_reg[0]  <= nabs[1:0];
            quo_reg[0] <= '0;
            d_reg[0]   <= d3_reg;
            neg_reg[0] <= n3[26];
            r_reg[0]   <= r3_reg;
        end
    end

    for (genvar j = 1; j <= DIV_BITS; j++) begin : g_div
        localparam int BI = DIV_BITS - j;
        logic        nb;
        logic [24:0] trial;
        logic        ge;
        always_comb begin
            nb    = (BI == 17) ? lo_reg[j-1][1] : ((BI == 16) ? lo_reg[j-1][0] : 1'b0);
            trial = {rem_reg[j-1], nb};
            ge    = trial >= {1'b0, d_reg[j-1]};
        end
        always_ff @(posedge aclk) begin
            if (ctrl.load[DIV_BASE+j]) begin
                rem_reg[j] <= ge ? 24'(trial - {1'b0, d_reg[j-1]}) : trial[23:0];
                quo_reg[j] <= {quo_reg[j-1][DIV_BITS-2:0], ge};
                d_reg[j]   <= d_reg[j-1];
                lo_reg[j]  <= lo_reg[j-1];
                neg_reg[j] <= neg_reg[j-1];
                r_reg[j]   <= r_reg[j-1];
            end
        end
    end

    // Final stage: sign the quotient and choose the lane result.
    logic signed [DIV_BITS:0] t;
    logic signed [31:0]       sig;
    logic signed [31:0]       y_reg;
    always_comb begin
        t   = neg_reg[DIV_BITS] ? -$signed({1'b0, quo_reg[DIV_BITS]})
                                :  $signed({1'b0, quo_reg[DIV_BITS]});
        sig = HALF_Q + 32'(t >>> 1);
    end
    always_ff @(posedge aclk) begin
        if (ctrl.load[NSTG-1]) begin
            y_reg <= (ctrl.mode == MODE_SIG) ? sig : r_reg[DIV_BITS];
        end
    end
    assign y = y_reg;
endmodule
`default_nettype wire

/* tb/sv/tb_top.sv */
// Self-checking testbench for the activation unit: random stimulus, stalls, scoreboard.
// Depends on nau_pkg and the neural_activation_unit top level.
`timescale 1ns / 1ps
module tb_top;
    import nau_pkg::*;

    typedef struct {
        logic [DATA_W-1:0] data;
        logic              last;
    } beat_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [7:0]        cfg_index = '0;
    logic [15:0]       cfg_data = '0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [DATA_W-1:0] s_tdata = '0;
    logic              s_tlast = 1'b0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [DATA_W-1:0] m_tdata;
    logic              m_tlast;

    neural_activation_unit dut (.*);

    initial begin
        forever #4 aclk = ~aclk;
    end

    // Configuration copy held by the predictor.
    logic [2:0]  cur_mode = 3'd0;
    logic [15:0] cur_slope = SLOPE_RST;

    beat_t pending_q[$];
    beat_t expected_q[$];
    int    mismatches = 0;
    int    idle_cycles = 0;
    bit    timed_out = 1'b0;
    bit    in_acc = 1'b0;
    int    gap_in = 0;
    int    gap_out = 0;

    function automatic int draw_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic signed [63:0] floor_shift(logic signed [63:0] v, int s);
        return v >>> s;
    endfunction

    // Sigmoid through the rational tanh approximation.
    function automatic logic signed [31:0] sigmoid_q(logic signed [31:0] x);
        logic signed [63:0] h, q, n, d, t;
        h = floor_shift(64'(x), 1);
        if (h > 64'(FIVE_Q)) h = 64'(FIVE_Q);
        if (h < -64'(FIVE_Q)) h = -64'(FIVE_Q);
        q = floor_shift(h * h, 16);
        n = floor_shift(h * (64'sd1769472 + q), 16);
        d = 64'sd1769472 + 9 * q;
        t = (n * 64'sd65536) / d;
        return 32'(64'sd32768 + floor_shift(t, 1));
    endfunction

    function automatic logic signed [31:0] activate_lane(logic signed [31:0] x);
        case (cur_mode)
            MODE_RELU:  return (x > 0) ? x : 32'sd0;
            MODE_RELU6: begin
                if (x < 0) return 32'sd0;
                return (x > SIX_Q) ? SIX_Q : x;
            end
            MODE_LEAKY: begin
                if (x > 0) return x;
                return 32'(floor_shift(64'(x) * $signed({48'd0, cur_slope}), 16));
            end
            MODE_SIG:   return sigmoid_q(x);
            default:    return x;
        endcase
    endfunction

    function automatic beat_t activate_beat(beat_t b);
        beat_t r;
        r.data = '0;
        for (int i = 0; i < LANES; i++)
            r.data[i*SW +: SW] = activate_lane(b.data[i*SW +: SW]);
        r.data[LANES*SW +: LCW] = b.data[LANES*SW +: LCW];
        r.last = b.last;
        return r;
    endfunction

    function automatic logic [31:0] pick_sample(int kind);
        case (kind)
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'd0;
            3: return 32'hFFFF_FFFF;
            4: return 32'd393216;
            5: return 32'd655360;
            6: return -32'sd655360;
            7: return 32'($signed($urandom_range(0, 1048576)) - 524288);
            default: return $urandom;
        endcase
    endfunction

    function automatic beat_t make_beat(int kind_hi, bit rand_lanes);
        beat_t b;
        b.data = '0;
        for (int i = 0; i < LANES; i++)
            b.data[i*SW +: SW] = pick_sample($urandom_range(0, kind_hi));
        b.data[LANES*SW +: LCW] = rand_lanes ? 4'($urandom) : 4'($urandom_range(1, 8));
        b.last = 1'($urandom_range(0, 1));
        return b;
    endfunction

    // Driver: beats change at the falling edge.
    always @(negedge aclk) begin
        if (aresetn) begin
            if (in_acc) begin
                // Accepted at the last rising edge.
                void'(pending_q.pop_front());
                gap_in = draw_gap();
            end
            if (gap_in > 0) begin
                gap_in--;
                s_tvalid <= 1'b0;
            end else if (pending_q.size() > 0) begin
                s_tvalid <= 1'b1;
                s_tdata  <= pending_q[0].data;
                s_tlast  <= pending_q[0].last;
            end else begin
                s_tvalid <= 1'b0;
            end
            if (gap_out > 0) begin
                gap_out--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                gap_out = draw_gap();
            end
        end
    end

    // Monitor: predict on accepted inputs, check accepted results.
    always @(posedge aclk) begin
        beat_t got, exp_b;
        in_acc = aresetn && s_tvalid && s_tready;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                got.data = s_tdata;
                got.last = s_tlast;
                expected_q.push_back(activate_beat(got));
            end
            if (m_tvalid && m_tready) begin
                if (expected_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result beat %h", m_tdata);
                end else begin
                    exp_b = expected_q.pop_front();
                    for (int i = 0; i < LANES; i++) begin
                        if (m_tdata[i*SW +: SW] !== exp_b.data[i*SW +: SW]) begin
                            mismatches++;
                            if (mismatches <= 10)
                                $display("lane %0d: expected %h got %h", i,
                                         exp_b.data[i*SW +: SW], m_tdata[i*SW +: SW]);
                        end
                    end
                    if (m_tdata[LANES*SW +: LCW] !== exp_b.data[LANES*SW +: LCW]) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("lane count: expected %h got %h",
                                     exp_b.data[LANES*SW +: LCW], m_tdata[LANES*SW +: LCW]);
                    end
                    if (m_tlast !== exp_b.last) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("last: expected %b got %b", exp_b.last, m_tlast);
                    end
                end
            end
            // Watchdog on cycles with no accepted beat.
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (pending_q.size() == 0 && expected_q.size() == 0))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles > 5000) timed_out = 1'b1;
        end
    end

    task automatic write_reg(logic [7:0] idx, logic [15:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        if (idx == REG_MODE) cur_mode = val[2:0];
        else if (idx == REG_SLOPE) cur_slope = val;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Let the queued beats drain, then the pipeline settle.
    task automatic drain();
        while ((pending_q.size() > 0 || expected_q.size() > 0) && !timed_out)
            @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    initial begin
        logic [15:0] slope_list[4];
        logic [2:0]  m;
        beat_t       b;
        slope_list = '{16'd0, 16'hFFFF, 16'd655, 16'h8000};
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: field extremes under every mode with the reset slope.
        for (int md = 0; md < 8; md++) begin
            if (md > 0) write_reg(REG_MODE, 16'(md));
            for (int k = 0; k < 3; k++) begin
                b = make_beat(7, 1'b1);
                if (k == 0) b.data[LANES*SW +: LCW] = 4'd0;
                if (k == 1) b.data[LANES*SW +: LCW] = 4'hF;
                pending_q.push_back(b);
            end
            drain();
        end
        // Writes to out-of-range indices, which the unit ignores.
        write_reg(8'd2, 16'hFFFF);
        write_reg(8'hFF, 16'h0001);

        // Random phases across modes and slopes.
        for (int ph = 0; ph < 26; ph++) begin
            m = (ph < 20) ? 3'(ph % 5) : 3'($urandom_range(0, 7));
            write_reg(REG_MODE, {13'd0, m});
            write_reg(REG_SLOPE, (ph < 4) ? slope_list[ph] : 16'($urandom));
            for (int n = 0; n < 50; n++)
                pending_q.push_back(make_beat(8, $urandom_range(0, 9) == 0));
            drain();
            if (timed_out) break;
        end

        if (timed_out) begin
            $display("[neural_activation_unit] ERROR");
            $finish;
        end
        if (mismatches == 0 && expected_q.size() == 0) begin
            $display("[neural_activation_unit] OK");
        end else begin
            $display("[neural_activation_unit] ERROR");
        end
        $finish;
    end
endmodule

/* neural_activation_unit.f */
+incdir+hdl
hdl/nau_pkg.sv
hdl/nau_flow.sv
hdl/nau_lane.sv
hdl/neural_activation_unit.sv
tb/sv/tb_top.sv
